// File: rtl/core/assert_macros.svh
// Assertion macros used by the congestion window core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/tcw_pkg.sv
// Shared types and constants of the congestion window unit.
package tcw_pkg;

    localparam int WINDOW_BITS_DEF = 32;
    localparam int MSS_BITS        = 16;
    localparam int LEN_BITS        = 32;
    localparam int DUP_BITS        = 16;

    localparam logic [MSS_BITS-1:0] MSS_RESET   = 16'd536;
    localparam logic [MSS_BITS-1:0] TIER_HIGH   = 16'd2190;
    localparam logic [MSS_BITS-1:0] TIER_MID    = 16'd1095;
    localparam logic [31:0]         THRESH_INIT = 32'h7FFF_FFFF;
    localparam logic [DUP_BITS-1:0] DUP_TRIGGER = 16'd3;

    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_DUP_ACK = 2'd3
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [LEN_BITS-1:0]   acked_length;
        logic [LEN_BITS-1:0]   bytes_in_flight;
        logic [DUP_BITS-1:0]   dup_ack_count;
    } t_event;

    typedef struct packed {
        logic [31:0] window_bytes;
        logic [31:0] slow_start_threshold;
        logic        in_fast_recovery;
    } t_result;

endpackage

// File: rtl/core/tcw_event_if.sv
// Event channel: one congestion event per item.
interface tcw_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] acked_length;
    logic [31:0] bytes_in_flight;
    logic [15:0] dup_ack_count;

    modport source (output valid, output action, output acked_length,
                    output bytes_in_flight, output dup_ack_count, input ready);
    modport sink   (input valid, input action, input acked_length,
                    input bytes_in_flight, input dup_ack_count, output ready);
endinterface

// File: rtl/core/tcw_result_if.sv
// Result channel: window, threshold and recovery flag per item.
interface tcw_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] window_bytes;
    logic [31:0] slow_start_threshold;
    logic        in_fast_recovery;

    modport source (output valid, output window_bytes, output slow_start_threshold,
                    output in_fast_recovery, input ready);
    modport sink   (input valid, input window_bytes, input slow_start_threshold,
                    input in_fast_recovery, output ready);
endinterface

// File: rtl/core/tcw_cfg_if.sv
// Configuration write channel for the segment size register.
interface tcw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_segment_size;

    modport source (output valid, output max_segment_size, input ready);
    modport sink   (input valid, input max_segment_size, output ready);
endinterface

// File: rtl/core/tcw_in_reg.sv
// Input register stage holding one accepted event.
module tcw_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tcw_pkg::t_event i_event,
    input  logic            i_advance,
    output logic            o_fire,
    output tcw_pkg::t_event o_event
);
    import tcw_pkg::*;

    logic   r_valid;
    t_event r_event;

    // The held item leaves whenever the result stage can take it, so a new
    // item may enter in the same cycle.
    assign o_ready = !r_valid || i_advance;
    assign o_fire  = r_valid && i_advance;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_event <= i_event;
        end
    end
endmodule

// File: rtl/core/tcw_out_reg.sv
// Result register stage driving the output channel.
module tcw_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tcw_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_advance,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

// File: rtl/core/tcw_core.sv
// Congestion state registers and the combinational next-state update per event.
`include "assert_macros.svh"

module tcw_core #(
    parameter int WINDOW_BITS = tcw_pkg::WINDOW_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::MSS_BITS-1:0]    i_cfg_mss,
    input  logic                            i_fire,
    input  tcw_pkg::t_event                 i_event,
    output tcw_pkg::t_result                o_result
);
    import tcw_pkg::*;

    // State saturates at the smaller of the parameter width and 32 bits.
    localparam int SW = (WINDOW_BITS < 32) ? WINDOW_BITS : 32;
    localparam int CW = 34;
    localparam logic [SW-1:0] SAT_LIMIT = '1;
    localparam logic [SW-1:0] THR_INIT  = (SW > 31) ? SW'(THRESH_INIT) : SAT_LIMIT;

    function automatic logic [SW-1:0] clamp(input logic [CW-1:0] v);
        return (v > CW'(SAT_LIMIT)) ? SAT_LIMIT : v[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] init_window(input logic [MSS_BITS-1:0] mss);
        logic [CW-1:0] m;
        m = CW'(mss);
        if (mss > TIER_HIGH) begin
            return clamp(m << 1);
        end else if (mss > TIER_MID) begin
            return clamp((m << 1) + m);
        end else begin
            return clamp(m << 2);
        end
    endfunction

    logic [MSS_BITS-1:0] r_mss;
    logic [SW-1:0]       r_window, n_window;
    logic [SW-1:0]       r_thresh, n_thresh;
    logic [SW-1:0]       r_acc,    n_acc;
    logic                r_flag,   n_flag;

    logic [CW-1:0]       mss_w;
    logic [MSS_BITS-1:0] ack_inc;
    logic [CW-1:0]       half_flight;
    logic [CW-1:0]       floor2;
    logic [SW-1:0]       loss_thr;
    logic [SW-1:0]       win_plus_inc;
    logic [SW-1:0]       win_plus_mss;
    logic [SW-1:0]       acc_sum;
    logic [SW-1:0]       dup_window;
    logic [SW-1:0]       mss_clamped;

    assign mss_w       = CW'(r_mss);
    assign ack_inc     = (i_event.acked_length < LEN_BITS'(r_mss)) ?
                         i_event.acked_length[MSS_BITS-1:0] : r_mss;
    assign half_flight = CW'(i_event.bytes_in_flight >> 1);
    assign floor2      = mss_w << 1;
    assign loss_thr    = clamp((half_flight > floor2) ? half_flight : floor2);
    assign win_plus_inc = clamp(CW'(r_window) + CW'(ack_inc));
    assign win_plus_mss = clamp(CW'(r_window) + mss_w);
    assign acc_sum      = clamp(CW'(r_acc) + CW'(i_event.acked_length));
    assign dup_window   = clamp(CW'(loss_thr) + (mss_w << 1) + mss_w);
    assign mss_clamped  = clamp(mss_w);

    always_comb begin
        n_window = r_window;
        n_thresh = r_thresh;
        n_acc    = r_acc;
        n_flag   = r_flag;
        unique case (i_event.action)
            ACT_INIT: begin
                n_window = init_window(r_mss);
                n_thresh = THR_INIT;
                n_acc    = '0;
                n_flag   = 1'b0;
            end
            ACT_ACK: begin
                if (r_flag) begin
                    // First new ack after any duplicate ack deflates the window to the threshold.
                    n_flag   = 1'b0;
                    n_window = r_thresh;
                end else if (r_window <= r_thresh) begin
                    n_window = win_plus_inc;
                end else if (acc_sum >= r_window) begin
                    n_window = win_plus_mss;
                    n_acc    = '0;
                end else begin
                    n_acc    = acc_sum;
                end
            end
            ACT_TIMEOUT: begin
                n_thresh = loss_thr;
                n_window = mss_clamped;
            end
            ACT_DUP_ACK: begin
                n_flag = 1'b1;
                if (i_event.dup_ack_count == DUP_TRIGGER) begin
                    n_thresh = loss_thr;
                    n_window = dup_window;
                end else if (i_event.dup_ack_count > DUP_TRIGGER) begin
                    n_window = win_plus_mss;
                end
            end
            default: begin
                n_flag = r_flag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss <= MSS_RESET;
        end else if (i_cfg_we) begin
            r_mss <= i_cfg_mss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= init_window(MSS_RESET);
            r_thresh <= THR_INIT;
            r_acc    <= '0;
            r_flag   <= 1'b0;
        end else if (i_fire) begin
            r_window <= n_window;
            r_thresh <= n_thresh;
            r_acc    <= n_acc;
            r_flag   <= n_flag;
        end
    end

    assign o_result.window_bytes         = 32'(n_window);
    assign o_result.slow_start_threshold = 32'(n_thresh);
    assign o_result.in_fast_recovery     = n_flag;

    `ASSERT_NEXT(a_init_clears, i_clk, i_rst_n, i_fire && i_event.action == ACT_INIT, r_acc == '0 && !r_flag)
    `ASSERT_NEXT(a_dup_sets_flag, i_clk, i_rst_n, i_fire && i_event.action == ACT_DUP_ACK, r_flag)
    `ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_fire, $stable(r_window) && $stable(r_thresh) && $stable(r_acc))
    `ASSERT_SAME(a_result_tracks_state, i_clk, i_rst_n, i_fire, o_result.in_fast_recovery == n_flag)
endmodule

// File: rtl/core/tcp_congestion_window_unit.sv
// An event is held in the input register, then its result in the result register.
// Throughput: one event per cycle while results are taken; state updates once per event.
// The event channel keeps taking items while a result waits, until both stages are full.
// Reset (synchronous, active low) sets segment size 536, window 2144,
// threshold 2147483647 (clamped to state width), byte accumulator and recovery flag clear.
module tcp_congestion_window_unit #(
    parameter int WINDOW_BITS = tcw_pkg::WINDOW_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcw_cfg_if.sink       i_cfg,
    tcw_event_if.sink     i_event,
    tcw_result_if.source  o_result
);
    import tcw_pkg::*;

    t_event  in_event;
    t_event  held_event;
    t_result next_result;
    t_result out_result;
    logic    fire;
    logic    advance;
    logic    in_ready;
    logic    out_valid;

    assign in_event.action          = t_action'(i_event.action);
    assign in_event.acked_length    = i_event.acked_length;
    assign in_event.bytes_in_flight = i_event.bytes_in_flight;
    assign in_event.dup_ack_count   = i_event.dup_ack_count;
    assign i_event.ready            = in_ready;

    // Segment size writes never stall.
    assign i_cfg.ready = 1'b1;

    tcw_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_event.valid),
        .o_ready   (in_ready),
        .i_event   (in_event),
        .i_advance (advance),
        .o_fire    (fire),
        .o_event   (held_event)
    );

    tcw_core #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_mss (i_cfg.max_segment_size),
        .i_fire    (fire),
        .i_event   (held_event),
        .o_result  (next_result)
    );

    tcw_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_result  (next_result),
        .i_ready   (o_result.ready),
        .o_valid   (out_valid),
        .o_advance (advance),
        .o_result  (out_result)
    );

    assign o_result.valid                = out_valid;
    assign o_result.window_bytes         = out_result.window_bytes;
    assign o_result.slow_start_threshold = out_result.slow_start_threshold;
    assign o_result.in_fast_recovery     = out_result.in_fast_recovery;
endmodule

// File: tb/sv/tcp_congestion_window_unit_test.sv
// Self-checking testbench of the TCP congestion window unit with its own window predictor.
`timescale 1ns / 100ps

module tcp_congestion_window_unit_test;
    import tcw_pkg::*;

    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    tcw_cfg_if    cfg ();
    tcw_event_if  ev ();
    tcw_result_if res ();

    tcp_congestion_window_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg),
        .i_event  (ev),
        .o_result (res)
    );

    // Predicted congestion state, kept in step with every accepted item.
    logic [15:0] seg_size;
    logic [31:0] win_bytes;
    logic [31:0] ssthresh;
    logic [31:0] acked_bytes;
    logic        fast_recovery;

    t_event  pending_events[$];
    t_result expected_results[$];
    bit      event_taken;
    int      idle_mode;
    int      mismatch_count;

    always #2 clk = ~clk;

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void load_initial_window();
        logic [63:0] seg;
        seg = {48'd0, seg_size};
        if (seg_size > TIER_HIGH) begin
            win_bytes = sat32(2 * seg);
        end else if (seg_size > TIER_MID) begin
            win_bytes = sat32(3 * seg);
        end else begin
            win_bytes = sat32(4 * seg);
        end
        ssthresh = sat32({32'd0, THRESH_INIT});
        acked_bytes = '0;
        fast_recovery = 1'b0;
    endfunction

    // Half the flight size, never below two segments.
    function automatic logic [31:0] loss_threshold(logic [31:0] flight);
        logic [63:0] half;
        logic [63:0] floor2;
        half = {32'd0, flight} >> 1;
        floor2 = 2 * {48'd0, seg_size};
        return sat32((half > floor2) ? half : floor2);
    endfunction

    function automatic t_result advance_window(t_event e);
        logic [63:0] seg;
        logic [63:0] len;
        t_result r;
        seg = {48'd0, seg_size};
        len = {32'd0, e.acked_length};
        case (e.action)
            ACT_INIT: begin
                load_initial_window();
            end
            ACT_ACK: begin
                if (fast_recovery) begin
                    fast_recovery = 1'b0;
                    win_bytes = ssthresh;
                end else if (win_bytes <= ssthresh) begin
                    win_bytes = sat32({32'd0, win_bytes} + ((len < seg) ? len : seg));
                end else begin
                    acked_bytes = sat32({32'd0, acked_bytes} + len);
                    if (acked_bytes >= win_bytes) begin
                        win_bytes = sat32({32'd0, win_bytes} + seg);
                        acked_bytes = '0;
                    end
                end
            end
            ACT_TIMEOUT: begin
                ssthresh = loss_threshold(e.bytes_in_flight);
                win_bytes = sat32(seg);
            end
            default: begin
                fast_recovery = 1'b1;
                if (e.dup_ack_count == DUP_TRIGGER) begin
                    ssthresh = loss_threshold(e.bytes_in_flight);
                    win_bytes = sat32({32'd0, ssthresh} + 3 * seg);
                end else if (e.dup_ack_count > DUP_TRIGGER) begin
                    win_bytes = sat32({32'd0, win_bytes} + seg);
                end
            end
        endcase
        r.window_bytes = win_bytes;
        r.slow_start_threshold = ssthresh;
        r.in_fast_recovery = fast_recovery;
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 38;
            1: return $urandom_range(99) < 83;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 83;
            1: return $urandom_range(99) < 38;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_event(t_action act, logic [31:0] len, logic [31:0] flight,
                                       logic [15:0] dups);
        t_event e;
        e.action = act;
        e.acked_length = len;
        e.bytes_in_flight = flight;
        e.dup_ack_count = dups;
        pending_events.push_back(e);
    endfunction

    function automatic logic [31:0] pick_acked_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) return $urandom_range(0, 2 * seg_size);
        if (sel < 70) return '0;
        if (sel < 90) return $urandom;
        return $urandom_range(1, 64);
    endfunction

    function automatic logic [31:0] pick_flight();
        if ($urandom_range(99) < 70) return $urandom_range(0, 16 * seg_size);
        return $urandom;
    endfunction

    // Mostly well-formed TCP event sequences with random content, plus some noise.
    function automatic void add_random_flow(int count);
        int          n;
        int          k;
        int          sel;
        logic [31:0] flight;
        n = 0;
        while (n < count) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                push_event(ACT_INIT, $urandom, $urandom, 16'($urandom));
                n++;
            end else if (sel < 45) begin
                k = $urandom_range(1, 8);
                repeat (k) push_event(ACT_ACK, pick_acked_length(), $urandom, 16'($urandom));
                n += k;
            end else if (sel < 65) begin
                k = $urandom_range(1, 6);
                flight = pick_flight();
                for (int d = 1; d <= k; d++) begin
                    push_event(ACT_DUP_ACK, $urandom, flight, 16'(d));
                end
                n += k;
                if ($urandom_range(99) < 80) begin
                    push_event(ACT_ACK, pick_acked_length(), $urandom, 16'($urandom));
                    n++;
                end
            end else if (sel < 75) begin
                push_event(ACT_TIMEOUT, $urandom, pick_flight(), 16'($urandom));
                n++;
            end else begin
                push_event(t_action'($urandom_range(0, 3)), $urandom, $urandom,
                           16'($urandom_range(0, 65535)));
                n++;
            end
        end
    endfunction

    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (pending_events.size() != 0 || expected_results.size() != 0 || ev.valid);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Segment size writes happen only with the unit idle.
    task automatic write_segment_size(logic [15:0] value);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.max_segment_size <= value;
        do begin
            @(posedge clk);
        end while (!(cfg.valid && cfg.ready));
        seg_size = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    always @(posedge clk) begin : event_accept
        t_event taken;
        if (rst_n && ev.valid && ev.ready) begin
            taken = pending_events.pop_front();
            expected_results.push_back(advance_window(taken));
            event_taken = 1'b1;
        end
    end

    always @(negedge clk) begin : event_driver
        t_event item;
        if (!rst_n) begin
            ev.valid <= 1'b0;
        end else if (ev.valid && !event_taken) begin
            // Hold the offered item until it is taken.
        end else if (pending_events.size() != 0 && !sender_idles()) begin
            item = pending_events[0];
            ev.valid <= 1'b1;
            ev.action <= item.action;
            ev.acked_length <= item.acked_length;
            ev.bytes_in_flight <= item.bytes_in_flight;
            ev.dup_ack_count <= item.dup_ack_count;
        end else begin
            ev.valid <= 1'b0;
        end
        event_taken = 1'b0;
    end

    always @(negedge clk) begin : result_ready_driver
        res.ready <= rst_n && !receiver_idles();
    end

    always @(posedge clk) begin : result_monitor
        t_result want;
        if (rst_n && res.valid && res.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no expected item: window %0d threshold %0d recovery %0b",
                       res.window_bytes, res.slow_start_threshold, res.in_fast_recovery);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (res.window_bytes !== want.window_bytes) begin
                    $error("window_bytes: expected %0d, got %0d",
                           want.window_bytes, res.window_bytes);
                    mismatch_count++;
                end
                if (res.slow_start_threshold !== want.slow_start_threshold) begin
                    $error("slow_start_threshold: expected %0d, got %0d",
                           want.slow_start_threshold, res.slow_start_threshold);
                    mismatch_count++;
                end
                if (res.in_fast_recovery !== want.in_fast_recovery) begin
                    $error("in_fast_recovery: expected %0b, got %0b",
                           want.in_fast_recovery, res.in_fast_recovery);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : run_limit
        #1_000_000;
        $error("timeout: %0d items pending, %0d results outstanding",
               pending_events.size(), expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : sequencer
        logic [15:0] sizes[9];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.max_segment_size = '0;
        ev.valid = 1'b0;
        ev.action = '0;
        ev.acked_length = '0;
        ev.bytes_in_flight = '0;
        ev.dup_ack_count = '0;
        res.ready = 1'b0;
        event_taken = 1'b0;
        idle_mode = 0;
        mismatch_count = 0;
        seg_size = MSS_RESET;
        load_initial_window();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset segment size.
        push_event(ACT_ACK, 32'd0, 32'd0, 16'd0);
        push_event(ACT_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_event(ACT_DUP_ACK, 32'd0, 32'd0, 16'd1);
        push_event(ACT_DUP_ACK, 32'd0, 32'd0, 16'd2);
        push_event(ACT_DUP_ACK, 32'd0, 32'hFFFF_FFFF, DUP_TRIGGER);
        push_event(ACT_DUP_ACK, 32'd0, 32'd0, 16'd4);
        push_event(ACT_DUP_ACK, 32'd0, 32'd0, 16'hFFFF);
        push_event(ACT_ACK, 32'd10, 32'd0, 16'd0);
        push_event(ACT_TIMEOUT, 32'd0, 32'd0, 16'd0);
        push_event(ACT_ACK, 32'd100, 32'd0, 16'd0);
        push_event(ACT_ACK, 32'd1000, 32'd0, 16'd0);
        // Congestion avoidance: a small ack, then one that saturates the byte count.
        push_event(ACT_ACK, 32'd5, 32'd0, 16'd0);
        push_event(ACT_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0);
        push_event(ACT_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 16'd0);
        push_event(ACT_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

        // Segment size tier boundaries, the largest size and the zero size.
        write_segment_size(TIER_MID);
        push_event(ACT_INIT, 32'd0, 32'd0, 16'd0);
        write_segment_size(TIER_HIGH);
        push_event(ACT_INIT, 32'd0, 32'd0, 16'd0);
        write_segment_size(TIER_HIGH + 16'd1);
        push_event(ACT_INIT, 32'd0, 32'd0, 16'd0);
        write_segment_size(16'hFFFF);
        push_event(ACT_INIT, 32'd0, 32'd0, 16'd0);
        push_event(ACT_DUP_ACK, 32'd0, 32'd0, DUP_TRIGGER);
        push_event(ACT_ACK, 32'd1, 32'd0, 16'd0);
        write_segment_size(16'd0);
        push_event(ACT_INIT, 32'd0, 32'd0, 16'd0);
        push_event(ACT_ACK, 32'd500, 32'd0, 16'd0);
        push_event(ACT_TIMEOUT, 32'd0, 32'd3, 16'd0);

        sizes = '{16'd536, 16'd1460, 16'hFFFF, 16'd1, 16'd2191, 16'd1095, 16'd0, 16'd0,
                  16'd4096};
        sizes[6] = 16'($urandom_range(1, 65535));
        for (int seg_idx = 0; seg_idx < 9; seg_idx++) begin
            write_segment_size(sizes[seg_idx]);
            idle_mode = seg_idx / 3;
            if (seg_idx == 4) begin
                // The sender stops until every outstanding result is back.
                add_random_flow(36);
                wait_drained();
                add_random_flow(36);
            end else begin
                add_random_flow(72);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
